FILE: design/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the scalar Kalman filter: register indexes,
// reset values, saturation limits, sequencer states and unit interfaces.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COV   = 2'd3;

    // 10.0, 1.0, 20.0 and 10.0 in Q16.16
    localparam logic [DATA_W-1:0] RST_MEAS_NOISE = 32'd655360;
    localparam logic [DATA_W-1:0] RST_MEAS_SCALE = 32'd65536;
    localparam logic [DATA_W-1:0] RST_PROC_NOISE = 32'd1310720;
    localparam logic [DATA_W-1:0] RST_INIT_COV   = 32'd655360;

    localparam logic [47:0] ONE_Q16 = 48'd65536;
    localparam logic [63:0] DM_CAP  = 64'h0000_0100_0000_0000;
    localparam logic [63:0] PR_CAP  = 64'h0000_0002_0000_0000;

    localparam logic [DATA_W-1:0] K_POS_LIM = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] K_NEG_LIM = 32'h8000_0000;

    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HP,
        S_HHP_LO,
        S_HHP_HI,
        S_DEN,
        S_DIV_START,
        S_INNOV,
        S_DIV_WAIT,
        S_DM_LO,
        S_DM_HI,
        S_DM_SUM,
        S_FACT,
        S_P_LO,
        S_P_HI,
        S_P_SUM,
        S_P_NEW
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] meas_noise;
        logic [DATA_W-1:0] meas_scale;
        logic [DATA_W-1:0] process_noise;
        logic [DATA_W-1:0] initial_cov;
    } t_cfg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_op;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic        zero;
        logic        ovf;
        logic [31:0] quot;
    } t_div_res;

    typedef struct packed {
        logic [DATA_W-1:0] estimate;
        logic [DATA_W-1:0] gain;
    } t_result;

endpackage

FILE: design/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter in Q16.16 with configuration registers and
// a registered result stage.
// ----------------------------------------------------------------------------
// A new item is accepted only once the previous one is done; the 32-step
// restoring divide for the gain sets most of the time per item, the rest
// is the shared multiplier sequence. A finished result waits in the output
// register while the next item starts.
// Reset: registers to defaults, estimate to zero, covariance to 10.0.
module scalar_kalman_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [skf_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [skf_pkg::DATA_W-1:0]   i_measurement,
    input  logic                                i_restart,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [skf_pkg::DATA_W-1:0]   o_estimate,
    output logic signed [skf_pkg::DATA_W-1:0]   o_gain
);

    import skf_pkg::*;

    t_cfg              r_cfg;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_est;
    logic [DATA_W-1:0] r_gain;

    logic              core_busy;
    logic              core_write;
    logic              out_free;
    logic              in_xfer;
    t_result           core_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.meas_noise    <= RST_MEAS_NOISE;
            r_cfg.meas_scale    <= RST_MEAS_SCALE;
            r_cfg.process_noise <= RST_PROC_NOISE;
            r_cfg.initial_cov   <= RST_INIT_COV;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MEAS_NOISE: r_cfg.meas_noise    <= i_cfg_data;
                CFG_MEAS_SCALE: r_cfg.meas_scale    <= i_cfg_data;
                CFG_PROC_NOISE: r_cfg.process_noise <= i_cfg_data;
                CFG_INIT_COV:   r_cfg.initial_cov   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_stall  = core_busy || !i_rst_n;
    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    skf_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_start       (in_xfer),
        .i_measurement (i_measurement),
        .i_restart     (i_restart),
        .i_out_free    (out_free),
        .o_busy        (core_busy),
        .o_write       (core_write),
        .o_result      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (core_write) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_write) begin
            r_est  <= core_res.estimate;
            r_gain <= core_res.gain;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_estimate = r_est;
    assign o_gain     = r_gain;

endmodule

FILE: design/skf_mul.sv
// ----------------------------------------------------------------------------
// skf_mul
// Shared 32 x 32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module skf_mul (
    input  logic             i_clk,
    input  skf_pkg::t_mul_op i_op,
    output logic [63:0]      o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_op.a) * 64'(i_op.b);
    end

    assign o_prod = r_prod;

endmodule

FILE: design/skf_div.sv
// ----------------------------------------------------------------------------
// skf_div
// Restoring divider, one quotient bit per cycle. Flags a zero divisor and a
// quotient that does not fit in 32 bits.
// ----------------------------------------------------------------------------
module skf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skf_pkg::t_div_req i_req,
    output skf_pkg::t_div_res o_res
);

    import skf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_zero;
    logic                 r_ovf;
    logic [63:0]          r_rem;
    logic [63:0]          r_den;
    logic [31:0]          r_num_lo;
    logic [31:0]          r_quot;

    logic [64:0]          trial;
    logic [64:0]          diff;
    logic                 take;

    always_comb begin
        trial = {r_rem, r_num_lo[31]};
        diff  = trial - {1'b0, r_den};
        take  = ~diff[64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder starts below the divisor unless the quotient overflows
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem    <= {32'd0, i_req.num[63:32]};
            r_num_lo <= i_req.num[31:0];
            r_den    <= i_req.den;
            r_zero   <= (i_req.den == 64'd0);
            r_ovf    <= (i_req.den[63:32] == 32'd0) && (i_req.num[63:32] >= i_req.den[31:0]);
        end else if (r_busy) begin
            r_rem    <= take ? diff[63:0] : trial[63:0];
            r_num_lo <= {r_num_lo[30:0], 1'b0};
            r_quot   <= {r_quot[30:0], take};
        end
    end

    always_comb begin
        o_res.done = r_done;
        o_res.zero = r_zero;
        o_res.ovf  = r_ovf;
        o_res.quot = r_quot;
    end

endmodule

FILE: design/skf_core.sv
// ----------------------------------------------------------------------------
// skf_core
// Sequencer and datapath of one filter step: gain, estimate and covariance
// update, all products through the shared multiplier.
// ----------------------------------------------------------------------------
module skf_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  skf_pkg::t_cfg               i_cfg,
    input  logic                        i_start,
    input  logic [skf_pkg::DATA_W-1:0]  i_measurement,
    input  logic                        i_restart,
    input  logic                        i_out_free,
    output logic                        o_busy,
    output logic                        o_write,
    output skf_pkg::t_result            o_result
);

    import skf_pkg::*;

    t_state      r_state;
    t_state      n_state;

    t_mul_op     mul_op;
    logic [63:0] prod;
    t_div_req    div_req;
    t_div_res    div_res;

    logic [31:0] r_x;
    logic [31:0] r_p;
    logic [31:0] r_u;
    logic [47:0] r_hp;
    logic [63:0] r_lo;
    logic [63:0] r_d;
    logic [31:0] r_k;
    logic [47:0] r_em;
    logic        r_eneg;
    logic [40:0] r_dm;
    logic [47:0] r_fm;
    logic        r_fneg;
    logic [63:0] r_pr;

    logic        h_neg;
    logic [31:0] h_mag;
    logic [31:0] x_mag;
    logic [63:0] wide_sum;
    logic [63:0] den_sum;
    logic [47:0] hx_mag;
    logic [48:0] u_ext;
    logic [48:0] innov;
    logic [48:0] innov_neg;
    logic [47:0] em;
    logic [31:0] k_lim;
    logic [31:0] k_sat;
    logic [31:0] gain;
    logic [40:0] dm_cap;
    logic [47:0] kh;
    logic        f_neg;
    logic [47:0] fm;
    logic [42:0] x_ext;
    logic [42:0] dm_ext;
    logic [42:0] nx;
    logic [31:0] nx_sat;
    logic [63:0] pr_cap;
    logic [34:0] np_sum;
    logic [31:0] np_pos;
    logic [31:0] np_neg;
    logic [31:0] p_next;

    skf_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (prod)
    );

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    // arithmetic on magnitudes, signs applied after
    always_comb begin
        h_neg     = i_cfg.meas_scale[31];
        h_mag     = h_neg ? (~i_cfg.meas_scale + 32'd1) : i_cfg.meas_scale;
        x_mag     = r_x[31] ? (~r_x + 32'd1) : r_x;

        // (lo + hi*2^32) >> 16
        wide_sum  = {16'd0, r_lo[63:16]} + {prod[47:0], 16'd0};
        den_sum   = wide_sum + {32'd0, i_cfg.meas_noise};

        hx_mag    = prod[63:16];
        u_ext     = {{17{r_u[31]}}, r_u};
        innov     = (h_neg ^ r_x[31]) ? (u_ext + {1'b0, hx_mag}) : (u_ext - {1'b0, hx_mag});
        innov_neg = ~innov + 49'd1;
        em        = innov[48] ? innov_neg[47:0] : innov[47:0];

        k_lim     = h_neg ? K_NEG_LIM : K_POS_LIM;
        if (div_res.zero) begin
            k_sat = 32'd0;
        end else if (div_res.ovf || (div_res.quot > k_lim)) begin
            k_sat = k_lim;
        end else begin
            k_sat = div_res.quot;
        end
        gain      = h_neg ? (~r_k + 32'd1) : r_k;

        dm_cap    = (wide_sum > DM_CAP) ? DM_CAP[40:0] : wide_sum[40:0];

        kh        = prod[63:16];
        f_neg     = kh > ONE_Q16;
        fm        = f_neg ? (kh - ONE_Q16) : (ONE_Q16 - kh);

        x_ext     = {{11{r_x[31]}}, r_x};
        dm_ext    = {2'b00, r_dm};
        nx        = (h_neg ^ r_eneg) ? (x_ext - dm_ext) : (x_ext + dm_ext);
        if ((nx[42:31] == 12'h000) || (nx[42:31] == 12'hFFF)) begin
            nx_sat = nx[31:0];
        end else begin
            nx_sat = nx[42] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end

        pr_cap    = (r_pr > PR_CAP) ? PR_CAP : r_pr;
        np_sum    = {1'b0, pr_cap[33:0]} + {3'd0, i_cfg.process_noise};
        np_pos    = (np_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : np_sum[31:0];
        np_neg    = ({32'd0, i_cfg.process_noise} > r_pr) ?
                    (i_cfg.process_noise - r_pr[31:0]) : 32'd0;
        p_next    = r_fneg ? np_neg : np_pos;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_HP;
                end
            end
            S_HP:        n_state = S_HHP_LO;
            S_HHP_LO:    n_state = S_HHP_HI;
            S_HHP_HI:    n_state = S_DEN;
            S_DEN:       n_state = S_DIV_START;
            S_DIV_START: n_state = S_INNOV;
            S_INNOV:     n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_res.done) begin
                    n_state = S_DM_LO;
                end
            end
            S_DM_LO:     n_state = S_DM_HI;
            S_DM_HI:     n_state = S_DM_SUM;
            S_DM_SUM:    n_state = S_FACT;
            S_FACT:      n_state = S_P_LO;
            S_P_LO:      n_state = S_P_HI;
            S_P_HI:      n_state = S_P_SUM;
            S_P_SUM:     n_state = S_P_NEW;
            S_P_NEW: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_op.a      = h_mag;
        mul_op.b      = r_p;
        div_req.start = 1'b0;
        div_req.num   = {r_hp, 16'd0};
        div_req.den   = r_d;
        o_write       = 1'b0;
        o_busy        = (r_state != S_IDLE);
        case (r_state)
            S_HHP_LO: begin
                mul_op.b = prod[47:16];
            end
            S_HHP_HI: begin
                mul_op.b = {16'd0, r_hp[47:32]};
            end
            S_DIV_START: begin
                mul_op.b      = x_mag;
                div_req.start = 1'b1;
            end
            S_DM_LO: begin
                mul_op.a = r_k;
                mul_op.b = r_em[31:0];
            end
            S_DM_HI: begin
                mul_op.a = r_k;
                mul_op.b = {16'd0, r_em[47:32]};
            end
            S_DM_SUM: begin
                mul_op.a = r_k;
                mul_op.b = h_mag;
            end
            S_P_LO: begin
                mul_op.a = r_fm[31:0];
            end
            S_P_HI: begin
                mul_op.a = {16'd0, r_fm[47:32]};
            end
            S_P_NEW: begin
                o_write = i_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x     <= 32'd0;
            r_p     <= RST_INIT_COV;
        end else begin
            r_state <= n_state;
            if ((r_state == S_IDLE) && i_start && i_restart) begin
                r_x <= 32'd0;
                r_p <= i_cfg.initial_cov;
            end
            if (r_state == S_FACT) begin
                r_x <= nx_sat;
            end
            if ((r_state == S_P_NEW) && i_out_free) begin
                r_p <= p_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_u <= i_measurement;
                end
            end
            S_HHP_LO:  r_hp <= prod[63:16];
            S_HHP_HI:  r_lo <= prod;
            S_DEN:     r_d  <= den_sum;
            S_INNOV: begin
                r_em   <= em;
                r_eneg <= innov[48];
            end
            S_DIV_WAIT: begin
                if (div_res.done) begin
                    r_k <= k_sat;
                end
            end
            S_DM_HI:   r_lo <= prod;
            S_DM_SUM:  r_dm <= dm_cap;
            S_FACT: begin
                r_fm   <= fm;
                r_fneg <= f_neg;
            end
            S_P_HI:    r_lo <= prod;
            S_P_SUM:   r_pr <= wide_sum;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.estimate = r_x;
        o_result.gain     = gain;
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scalar Kalman filter. A bit-exact Q16.16
// predictor tracks the estimate and covariance. Each accepted measurement
// pushes its expected estimate and gain, and each output transfer is checked
// against the oldest one. A directed set covers extremes, zero denominator,
// gain and estimate saturation, and covariance clamping. Random phases then
// run noisy tracking sequences under new filter settings, with varied
// source idling and sink stalling.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [31:0] meas;
        logic        rst;
    } t_meas_item;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                              i_clk      = 1'b0;
    logic                              i_rst_n    = 1'b0;
    logic                              i_cfg_we   = 1'b0;
    logic [skf_pkg::CFG_IDX_W-1:0]     i_cfg_idx  = '0;
    logic [skf_pkg::DATA_W-1:0]        i_cfg_data = '0;
    logic                              i_valid    = 1'b0;
    logic                              o_stall;
    logic signed [skf_pkg::DATA_W-1:0] i_measurement = '0;
    logic                              i_restart  = 1'b0;
    logic                              o_valid;
    logic                              i_stall    = 1'b0;
    logic signed [skf_pkg::DATA_W-1:0] o_estimate;
    logic signed [skf_pkg::DATA_W-1:0] o_gain;

    scalar_kalman_filter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_measurement (i_measurement),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_estimate    (o_estimate),
        .o_gain        (o_gain)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // filter settings and state as seen by the predictor
    skf_pkg::t_cfg    cfg;
    logic [31:0]      kf_est;
    logic [31:0]      kf_cov;

    t_meas_item       meas_q[$];
    skf_pkg::t_result est_q[$];
    t_meas_item       drv_item;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int errors        = 0;
    int n_sent        = 0;
    int n_seen        = 0;
    int n_restart     = 0;
    int n_checked     = 0;
    int n_settings    = 0;
    int n_gain_sat    = 0;

    function automatic skf_pkg::t_result kalman_step(input logic [31:0] meas,
                                                     input logic restart);
        skf_pkg::t_result res;
        longint      h, x, hx, u, e, nx, f;
        logic [63:0] a, p, hp, hhp, d, kmag, klim, xm, hxm, em, dm, kh, fm, prod, np, q;
        logic        hneg, xneg, eneg;
        if (restart) begin
            kf_est = '0;
            kf_cov = cfg.initial_cov;
        end
        h    = $signed({{32{cfg.meas_scale[31]}}, cfg.meas_scale});
        hneg = h < 0;
        a    = hneg ? -h : h;
        p    = {32'b0, kf_cov};

        // gain, all on magnitudes and truncated
        hp   = (a * p) >> 16;
        hhp  = a * (hp >> 16) + ((a * (hp & 64'hFFFF)) >> 16);
        d    = hhp + {32'b0, cfg.meas_noise};
        kmag = (d == 0) ? 64'd0 : (hp << 16) / d;
        klim = hneg ? {32'b0, skf_pkg::K_NEG_LIM} : {32'b0, skf_pkg::K_POS_LIM};
        if (kmag > klim) begin
            kmag = klim;
            n_gain_sat++;
        end
        res.gain = hneg ? -kmag[31:0] : kmag[31:0];

        // estimate
        x    = $signed({{32{kf_est[31]}}, kf_est});
        xneg = x < 0;
        xm   = xneg ? -x : x;
        hxm  = (a * xm) >> 16;
        hx   = (hneg != xneg) ? -$signed(hxm) : $signed(hxm);
        u    = $signed({{32{meas[31]}}, meas});
        e    = u - hx;
        eneg = e < 0;
        em   = eneg ? -e : e;
        dm   = kmag * (em >> 16) + ((kmag * (em & 64'hFFFF)) >> 16);
        if (dm > skf_pkg::DM_CAP)
            dm = skf_pkg::DM_CAP;
        nx = x + ((hneg != eneg) ? -$signed(dm) : $signed(dm));
        if (nx > 64'sd2147483647)
            nx = 64'sd2147483647;
        if (nx < -64'sd2147483648)
            nx = -64'sd2147483648;
        kf_est = nx[31:0];

        // covariance, clamped to the unsigned range
        kh = (kmag * a) >> 16;
        f  = 64'sd65536 - $signed(kh);
        fm = (f < 0) ? -f : f;
        if (fm > 64'hFFFF_FFFF_FFFF)
            fm = 64'hFFFF_FFFF_FFFF;
        prod = fm * (p >> 16) + ((fm * (p & 64'hFFFF)) >> 16);
        q    = {32'b0, cfg.process_noise};
        if (f >= 0) begin
            if (prod > skf_pkg::PR_CAP)
                prod = skf_pkg::PR_CAP;
            np = prod + q;
            if (np > 64'hFFFF_FFFF)
                np = 64'hFFFF_FFFF;
        end else begin
            np = (q > prod) ? q - prod : 64'd0;
        end
        kf_cov = np[31:0];

        res.estimate = kf_est;
        return res;
    endfunction

    // source: capture transfers at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            est_q.push_back(kalman_step(i_measurement, i_restart));
            n_sent++;
            if (i_restart)
                n_restart++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || (n_seen != n_sent)) begin
            n_seen = n_sent;
            if (meas_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_item = meas_q.pop_front();
                i_valid       <= 1'b1;
                i_measurement <= drv_item.meas;
                i_restart     <= drv_item.rst;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // sink
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (est_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: estimate %h gain %h",
                         $time, o_estimate, o_gain);
            end else begin
                skf_pkg::t_result want;
                want = est_q.pop_front();
                n_checked++;
                if (o_estimate !== want.estimate) begin
                    errors++;
                    $display("%0t estimate: expected %h, actual %h",
                             $time, want.estimate, o_estimate);
                end
                if (o_gain !== want.gain) begin
                    errors++;
                    $display("%0t gain: expected %h, actual %h",
                             $time, want.gain, o_gain);
                end
            end
        end
    end

    task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_filter(input logic [31:0] r, input logic [31:0] h,
                              input logic [31:0] q, input logic [31:0] p0);
        write_reg(skf_pkg::CFG_MEAS_NOISE, r);
        write_reg(skf_pkg::CFG_MEAS_SCALE, h);
        write_reg(skf_pkg::CFG_PROC_NOISE, q);
        write_reg(skf_pkg::CFG_INIT_COV, p0);
        cfg.meas_noise    = r;
        cfg.meas_scale    = h;
        cfg.process_noise = q;
        cfg.initial_cov   = p0;
        n_settings++;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 83; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 83; end
            IDLE_BOTH:     begin send_idle_pct = 21; stall_pct = 21; end
            default:       begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic queue_meas(input logic [31:0] meas, input logic rst);
        t_meas_item it;
        it.meas = meas;
        it.rst  = rst;
        meas_q.push_back(it);
    endtask

    // wait until every measurement is transferred and every result is back
    task automatic drain();
        do
            @(posedge i_clk);
        while (meas_q.size() != 0 || i_valid || est_q.size() != 0);
    endtask

    function automatic logic [31:0] rand_level();
        case ($urandom_range(11))
            0:       return $urandom();
            1:       return '0;
            2:       return '1;
            default: return $urandom_range(32'h0064_0000, 32'h0000_0100);
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        logic [31:0] v;
        case ($urandom_range(11))
            0:       return $urandom();
            1:       return '0;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: begin
                v = $urandom_range(32'h0004_0000, 32'h0000_4000);
                return $urandom_range(1) ? -v : v;
            end
        endcase
    endfunction

    // noisy samples around a target that jumps now and then
    task automatic queue_track(input int count);
        int centre;
        int noise;
        centre = int'($urandom_range(131_072_000)) - 65_536_000;
        for (int i = 0; i < count; i++) begin
            logic [31:0] m;
            case ($urandom_range(19))
                0, 1: m = $urandom();
                2:    m = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: begin
                    noise = int'($urandom_range(655_360)) - 327_680;
                    m = centre + noise;
                end
            endcase
            queue_meas(m, (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(24) == 0));
            if ($urandom_range(49) == 0)
                centre = int'($urandom_range(131_072_000)) - 65_536_000;
        end
    endtask

    initial begin
        cfg.meas_noise    = skf_pkg::RST_MEAS_NOISE;
        cfg.meas_scale    = skf_pkg::RST_MEAS_SCALE;
        cfg.process_noise = skf_pkg::RST_PROC_NOISE;
        cfg.initial_cov   = skf_pkg::RST_INIT_COV;
        kf_est = '0;
        kf_cov = skf_pkg::RST_INIT_COV;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, measurement extremes
        set_idling(IDLE_NONE);
        queue_meas(32'h0000_0000, 1'b0);
        queue_meas(32'h7FFF_FFFF, 1'b0);
        queue_meas(32'h8000_0000, 1'b0);
        queue_meas(32'hFFFF_FFFF, 1'b0);
        queue_meas(32'h0000_0001, 1'b1);
        queue_meas(32'h0001_0000, 1'b0);
        queue_meas($urandom(), 1'b1);
        drain();

        // zero denominator
        set_filter(32'h0, 32'h0, 32'h0001_0000, 32'h000A_0000);
        queue_meas(32'h0005_0000, 1'b1);
        queue_meas(32'hFFF0_0000, 1'b0);
        drain();

        // gain saturates, estimate overflows, both signs of H
        set_filter(32'h1, 32'h1, 32'h0, 32'hFFFF_FFFF);
        queue_meas(32'h7FFF_FFFF, 1'b1);
        queue_meas(32'h8000_0000, 1'b0);
        drain();
        set_filter(32'h1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        queue_meas(32'h7FFF_FFFF, 1'b1);
        queue_meas(32'h8000_0000, 1'b0);
        drain();

        // K*H just above one: covariance clamps at zero or falls short of Q
        set_filter(32'h0, 32'd300, 32'h0, 32'hFFFF_FFFF);
        queue_meas(32'h0001_0000, 1'b1);
        queue_meas(32'h0002_0000, 1'b0);
        drain();
        set_filter(32'h0, 32'd300, 32'd100_000, 32'hFFFF_FFFF);
        queue_meas(32'h0001_0000, 1'b1);
        drain();

        // register extremes, covariance clamps high
        set_filter(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_meas(32'h8000_0000, 1'b1);
        queue_meas(32'h7FFF_FFFF, 1'b0);
        drain();
        set_filter(32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
        queue_meas(32'h7FFF_FFFF, 1'b1);
        queue_meas(32'h1234_5678, 1'b0);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            set_filter(rand_level(), rand_scale(), rand_level(), rand_level());
            set_idling(t_idle_mode'(ph % 4));
            if (ph == 5) begin
                queue_track(41);
                drain();
                queue_track(41);
            end else begin
                queue_track(82);
            end
            drain();
        end

        repeat (60) @(posedge i_clk);
        $display("Covered %0d measurements (%0d with restart) over %0d filter settings.",
                 n_sent, n_restart, n_settings);
        $display("Compared %0d results, %0d of them with a saturated gain.",
                 n_checked, n_gain_sat);
        if (errors == 0 && est_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
